// File: sv/cpt_pkg.sv
// Shared types and codes of the card presence tracker.
`default_nettype none

package cpt_pkg;

   localparam int ByteW    = 8;
   localparam int UidBytes = 7;
   localparam int UidW     = UidBytes * ByteW;
   localparam int AtqaW    = 16;
   localparam int FailW    = 16;
   localparam int CsrIdxW  = 2;
   localparam int CsrDataW = 8;

   // Poll status codes.
   localparam logic [2:0] POLL_NONE     = 3'd0;
   localparam logic [2:0] POLL_FATAL    = 3'd1;
   localparam logic [2:0] POLL_ANTICOLL = 3'd2;
   localparam logic [2:0] POLL_UID4     = 3'd3;
   localparam logic [2:0] POLL_UID7     = 3'd4;

   // Event codes.
   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_NEW     = 3'd1;
   localparam logic [2:0] EV_CHANGED = 3'd2;
   localparam logic [2:0] EV_PRESENT = 3'd3;
   localparam logic [2:0] EV_REMOVED = 3'd4;

   // UID lengths.
   localparam logic [2:0] LEN_NONE = 3'd0;
   localparam logic [2:0] LEN_UID4 = 3'd4;
   localparam logic [2:0] LEN_UID7 = 3'd7;

   // Register indexes and reset values.
   localparam logic [CsrIdxW-1:0]  CSR_REMOVAL_THRESHOLD = 2'd0;
   localparam logic [CsrIdxW-1:0]  CSR_RECOVERY_INTERVAL = 2'd1;
   localparam logic [CsrDataW-1:0] THRESHOLD_RESET       = 8'd5;
   localparam logic [CsrDataW-1:0] INTERVAL_RESET        = 8'd30;

   // UID plausibility constants.
   localparam logic [ByteW-1:0] BYTE_CASCADE = 8'h88;
   localparam logic [ByteW-1:0] BYTE_ZERO    = 8'h00;
   localparam logic [ByteW-1:0] BYTE_ONES    = 8'hFF;

   typedef struct packed {
      logic [2:0]       poll_status;
      logic [AtqaW-1:0] atqa;
      logic [UidW-1:0]  uid_in;
   } req_type;

   typedef struct packed {
      logic [2:0]      event_res;
      logic [2:0]      uid_len;
      logic [UidW-1:0] uid_out;
      logic            use_wakeup;
      logic            rf_recover;
   } rsp_type;

endpackage

`default_nettype wire

// File: sv/card_presence_tracker.sv
// Top level of the card presence tracker: poll evaluation, state and recovery check.
`default_nettype none

// Card presence tracker. Each req_ transfer is the outcome of one poll; each one
// yields exactly one rsp_ transfer carrying the event, the UID to report, the
// WUPA hint for the next poll and an RF recovery request. When no recovery check
// is needed a poll passes through the idle state that ends in its acceptance,
// evaluate, and hand off; the result register loads at the hand-off. A failed
// poll while no card is present, with a nonzero recovery interval, also runs
// the fail count through a restoring remainder loop between evaluate and hand
// off: one bit per cycle through a single 9-bit subtract and compare, for each
// bit of the 16-bit count. The hand-off waits as long as the previous result
// still sits under rsp_stall. req_stall is high while a poll is being worked
// on; a new poll is taken as soon as the sequencer is back idle, even while the
// previous result still waits under rsp_stall. The two configuration registers
// are written through csr_, which is always ready; write them only while the
// block is idle.
module card_presence_tracker (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_valid,
   output logic                           req_stall,
   input  cpt_pkg::req_type               req_data,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output cpt_pkg::rsp_type               rsp_data,
   input  wire                            csr_valid,
   output logic                           csr_ready,
   input  wire  [cpt_pkg::CsrIdxW-1:0]    csr_index,
   input  wire  [cpt_pkg::CsrDataW-1:0]   csr_wdata
);

   localparam int FailW = cpt_pkg::FailW;
   localparam int CntW  = $clog2(FailW);
   localparam int RemW  = cpt_pkg::CsrDataW;
   localparam logic [CntW-1:0] CntLast = CntW'(FailW - 1);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EVAL = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]                   state_ff, state_in;
   cpt_pkg::req_type             poll_ff, poll_in;
   cpt_pkg::rsp_type             rsp_data_ff, rsp_data_in;
   logic                         rsp_valid_ff, rsp_valid_in;

   // Architectural state.
   logic                         present_ff, present_in;
   logic [FailW-1:0]             fail_ff, fail_in;
   logic [cpt_pkg::UidW-1:0]     last_uid_ff, last_uid_in;
   logic [2:0]                   last_len_ff, last_len_in;
   logic [RemW-1:0]              threshold_ff, threshold_in;
   logic [RemW-1:0]              interval_ff, interval_in;

   // Result under construction.
   logic [2:0]                   ev_ff, ev_in;
   logic [2:0]                   rlen_ff, rlen_in;
   logic [cpt_pkg::UidW-1:0]     ruid_ff, ruid_in;
   logic                         check_ff, check_in;

   // Remainder unit.
   logic [FailW-1:0]             div_ff, div_in;
   logic [RemW-1:0]              rem_ff, rem_in;
   logic [CntW-1:0]              cnt_ff, cnt_in;
   logic [RemW:0]                rem_trial;
   logic [RemW:0]                ivl_ext;

   // Poll decode.
   logic [cpt_pkg::ByteW-1:0]    uid_byte [cpt_pkg::UidBytes];
   logic [cpt_pkg::UidBytes-1:0] byte_varied;
   logic                         is_uid4, is_uid7;
   logic [cpt_pkg::UidW-1:0]     uid_eff;
   logic [2:0]                   len_eff;
   logic                         uid_valid;
   logic [FailW-1:0]             fail_inc;

   // Split the captured UID into bytes and flag the ones that carry information.
   always_comb begin
      for (int i = 0; i < cpt_pkg::UidBytes; i++) begin
         uid_byte[i]    = poll_ff.uid_in[i*cpt_pkg::ByteW +: cpt_pkg::ByteW];
         byte_varied[i] = (uid_byte[i] != cpt_pkg::BYTE_ZERO) &&
                          (uid_byte[i] != cpt_pkg::BYTE_ONES);
      end
   end

   assign is_uid4 = (poll_ff.poll_status == cpt_pkg::POLL_UID4);
   assign is_uid7 = (poll_ff.poll_status == cpt_pkg::POLL_UID7);
   assign len_eff = is_uid4 ? cpt_pkg::LEN_UID4 : cpt_pkg::LEN_UID7;
   // Drop the upper three bytes of a four-byte UID.
   assign uid_eff = is_uid4 ? {24'd0, poll_ff.uid_in[31:0]} : poll_ff.uid_in;

   // UID plausibility: any of these rules rejects the poll as a failure.
   always_comb begin
      uid_valid = 1'b0;
      if (is_uid4) begin
         uid_valid = (|byte_varied[3:1]) && (uid_byte[0] != cpt_pkg::BYTE_CASCADE);
      end else if (is_uid7) begin
         uid_valid = (|byte_varied[6:1]) &&
                     (uid_byte[3] != cpt_pkg::BYTE_CASCADE) &&
                     (poll_ff.uid_in[55:24] != 32'h0000_0000) &&
                     (poll_ff.uid_in[55:24] != 32'hFFFF_FFFF);
      end
      if (poll_ff.atqa == 16'hFFFF || uid_byte[0] == cpt_pkg::BYTE_ZERO) begin
         uid_valid = 1'b0;
      end
   end

   // The fail count wraps at its width.
   assign fail_inc = fail_ff + FailW'(1);

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign rem_trial = {rem_ff, div_ff[FailW-1]};
   assign ivl_ext   = {1'b0, interval_ff};

   always_comb begin
      state_in     = state_ff;
      poll_in      = poll_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      present_in   = present_ff;
      fail_in      = fail_ff;
      last_uid_in  = last_uid_ff;
      last_len_in  = last_len_ff;
      threshold_in = threshold_ff;
      interval_in  = interval_ff;
      ev_in        = ev_ff;
      rlen_in      = rlen_ff;
      ruid_in      = ruid_ff;
      check_in     = check_ff;
      div_in       = div_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;

      // Retire the waiting result once the consumer takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes; indexes beyond the list are dropped.
      if (csr_valid) begin
         case (csr_index)
            cpt_pkg::CSR_REMOVAL_THRESHOLD: threshold_in = csr_wdata;
            cpt_pkg::CSR_RECOVERY_INTERVAL: interval_in  = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               poll_in  = req_data;
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            ev_in    = cpt_pkg::EV_NONE;
            rlen_in  = cpt_pkg::LEN_NONE;
            ruid_in  = '0;
            check_in = 1'b0;
            if (uid_valid) begin
               fail_in = '0;
               rlen_in = len_eff;
               ruid_in = uid_eff;
               if (!present_ff) begin
                  present_in  = 1'b1;
                  last_uid_in = uid_eff;
                  last_len_in = len_eff;
                  ev_in       = cpt_pkg::EV_NEW;
               end else if (len_eff != last_len_ff || uid_eff != last_uid_ff) begin
                  last_uid_in = uid_eff;
                  last_len_in = len_eff;
                  ev_in       = cpt_pkg::EV_CHANGED;
               end else begin
                  ev_in = cpt_pkg::EV_PRESENT;
               end
            end else if (poll_ff.poll_status == cpt_pkg::POLL_ANTICOLL) begin
               // A card answered: not a miss, but nothing new to report.
               fail_in = '0;
               if (present_ff) begin
                  rlen_in = last_len_ff;
                  ruid_in = last_uid_ff;
                  ev_in   = cpt_pkg::EV_PRESENT;
               end
            end else begin
               fail_in = fail_inc;
               if (present_ff) begin
                  if (fail_inc >= FailW'(threshold_ff)) begin
                     present_in = 1'b0;
                     ev_in      = cpt_pkg::EV_REMOVED;
                  end else begin
                     rlen_in = last_len_ff;
                     ruid_in = last_uid_ff;
                     ev_in   = cpt_pkg::EV_PRESENT;
                  end
               end else begin
                  check_in = (interval_ff != '0) && (fail_inc != '0);
               end
            end
            div_in   = fail_inc;
            rem_in   = '0;
            cnt_in   = '0;
            state_in = check_in ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            div_in = {div_ff[FailW-2:0], 1'b0};
            if (rem_trial >= ivl_ext) begin
               rem_in = RemW'(rem_trial - ivl_ext);
            end else begin
               rem_in = rem_trial[RemW-1:0];
            end
            cnt_in = cnt_ff + CntW'(1);
            if (cnt_ff == CntLast) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hold until the result register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.event_res  = ev_ff;
               rsp_data_in.uid_len    = rlen_ff;
               rsp_data_in.uid_out    = ruid_ff;
               rsp_data_in.use_wakeup = present_ff;
               rsp_data_in.rf_recover = check_ff && (rem_ff == '0);
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         present_ff   <= 1'b0;
         fail_ff      <= '0;
         last_uid_ff  <= '0;
         last_len_ff  <= cpt_pkg::LEN_NONE;
         threshold_ff <= cpt_pkg::THRESHOLD_RESET;
         interval_ff  <= cpt_pkg::INTERVAL_RESET;
         check_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         present_ff   <= present_in;
         fail_ff      <= fail_in;
         last_uid_ff  <= last_uid_in;
         last_len_ff  <= last_len_in;
         threshold_ff <= threshold_in;
         interval_ff  <= interval_in;
         check_ff     <= check_in;
         cnt_ff       <= cnt_in;
      end
      poll_ff     <= poll_in;
      rsp_data_ff <= rsp_data_in;
      ev_ff       <= ev_in;
      rlen_ff     <= rlen_in;
      ruid_ff     <= ruid_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

`ifndef NO_ASSERTIONS
   // The partial remainder stays below the interval throughout the loop.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < interval_ff))
      else $error("remainder out of range during recovery check");

   // An accepted poll is evaluated in the very next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EVAL))
      else $error("accepted poll not evaluated");

   // Recovery is only requested with no card present.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.rf_recover) |-> !rsp_data.use_wakeup)
      else $error("recovery requested while card present");

   // A removal reports no UID and ends presence.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.event_res == cpt_pkg::EV_REMOVED) |->
      (rsp_data.uid_len == cpt_pkg::LEN_NONE && !rsp_data.use_wakeup))
      else $error("removal result inconsistent");
`endif

endmodule

`default_nettype wire
